// ===== src/stable_rank_argsort_core_macros.svh =====
// Assertion macros for the module that checks itself, stable_rank_argsort_core.
`ifndef STABLE_RANK_ARGSORT_CORE_MACROS_SVH
`define STABLE_RANK_ARGSORT_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SRAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SRAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/srac_pkg.sv =====
package srac_pkg;

  localparam int DEF_MAX_LEN   = 64;
  localparam int DEF_KEY_WIDTH = 32;
  localparam int IN_KEY_WIDTH  = 32;
  localparam int EXT_WIDTH     = 64;
  localparam int IDX_WIDTH     = 6;
  localparam int CNT_WIDTH     = 7;

  typedef struct packed {
    logic ins;
    logic pop;
  } srac_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } srac_state_t;

endpackage

// ===== src/srac_cell.sv =====
module srac_cell
  import srac_pkg::*;
#(
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic                 clk,
  input  srac_ctl_t            ctl,
  input  logic                 occupied,
  input  logic [KEY_WIDTH-1:0] new_key,
  input  logic [IDX_WIDTH-1:0] new_idx,
  input  logic                 prev_gt,
  input  logic [KEY_WIDTH-1:0] prev_key,
  input  logic [IDX_WIDTH-1:0] prev_idx,
  input  logic [KEY_WIDTH-1:0] next_key,
  input  logic [IDX_WIDTH-1:0] next_idx,
  output logic                 gt,
  output logic [KEY_WIDTH-1:0] key,
  output logic [IDX_WIDTH-1:0] idx
);

  // A stored key strictly greater than the new one moves one place down the row.
  assign gt = occupied && ($signed(new_key) < $signed(key));

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      key <= next_key;
      idx <= next_idx;
    end else if (ctl.ins && (!occupied || gt)) begin
      if (prev_gt) begin
        key <= prev_key;
        idx <= prev_idx;
      end else begin
        key <= new_key;
        idx <= new_idx;
      end
    end
  end

endmodule

// ===== src/stable_rank_argsort_core.sv =====
// Stable ascending argsort over a row of MAX_LEN compare-and-shift cells. Keys
// are taken one per cycle while loading, and each key is inserted in the same
// cycle by having every cell compare it with its stored key in parallel, so
// equal keys keep their arrival order. The transaction marked is_final ends the
// vector; the block then stalls its input and delivers one transaction per stored
// key, popping cell 0 each cycle unless result_stall holds it. Keys beyond MAX_LEN
// are dropped and every result of that vector is flagged overflowed.
module stable_rank_argsort_core
  import srac_pkg::*;
#(
  parameter int MAX_LEN   = DEF_MAX_LEN,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [IN_KEY_WIDTH-1:0] key_value,
  input  logic                    is_final,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [IDX_WIDTH-1:0]    sorted_index,
  output logic                    end_of_run,
  output logic                    overflowed
);

`include "stable_rank_argsort_core_macros.svh"

  srac_state_t          state;
  srac_state_t          state_next;
  logic [CNT_WIDTH-1:0] count;
  logic [CNT_WIDTH-1:0] count_next;
  logic                 drop;
  logic                 drop_next;

  logic                 item_take;
  logic                 result_take;
  logic                 has_room;
  srac_ctl_t            ctl;

  logic [EXT_WIDTH-1:0] key_ext;
  logic [KEY_WIDTH-1:0] new_key;

  logic [KEY_WIDTH-1:0] keys [MAX_LEN];
  logic [IDX_WIDTH-1:0] idxs [MAX_LEN];
  logic                 gts  [MAX_LEN];

  assign item_stall   = (state != ST_LOAD);
  assign result_valid = (state == ST_DRAIN);
  assign item_take    = item_valid && !item_stall;
  assign result_take  = result_valid && !result_stall;
  assign has_room     = (count < CNT_WIDTH'(MAX_LEN));

  assign ctl.ins = item_take && has_room;
  assign ctl.pop = result_take;

  assign key_ext = {{(EXT_WIDTH - IN_KEY_WIDTH){key_value[IN_KEY_WIDTH-1]}}, key_value};
  assign new_key = key_ext[KEY_WIDTH-1:0];

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic                 prev_gt;
    logic [KEY_WIDTH-1:0] prev_key;
    logic [IDX_WIDTH-1:0] prev_idx;
    logic [KEY_WIDTH-1:0] next_key;
    logic [IDX_WIDTH-1:0] next_idx;

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_key = '0;
      assign prev_idx = '0;
    end else begin : g_body
      assign prev_gt  = gts[i-1];
      assign prev_key = keys[i-1];
      assign prev_idx = idxs[i-1];
    end

    if (i == MAX_LEN - 1) begin : g_tail
      assign next_key = '0;
      assign next_idx = '0;
    end else begin : g_link
      assign next_key = keys[i+1];
      assign next_idx = idxs[i+1];
    end

    srac_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (count > CNT_WIDTH'(i)),
      .new_key  (new_key),
      .new_idx  (count[IDX_WIDTH-1:0]),
      .prev_gt  (prev_gt),
      .prev_key (prev_key),
      .prev_idx (prev_idx),
      .next_key (next_key),
      .next_idx (next_idx),
      .gt       (gts[i]),
      .key      (keys[i]),
      .idx      (idxs[i])
    );
  end

  assign sorted_index = idxs[0];
  assign end_of_run   = (count == CNT_WIDTH'(1));
  assign overflowed   = drop;

  always_comb begin
    state_next = state;
    count_next = count;
    drop_next  = drop;
    unique case (state)
      ST_LOAD: begin
        if (item_take) begin
          if (has_room) begin
            count_next = count + CNT_WIDTH'(1);
          end else begin
            drop_next = 1'b1;
          end
          if (is_final) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (result_take) begin
          count_next = count - CNT_WIDTH'(1);
          if (end_of_run) begin
            state_next = ST_LOAD;
            drop_next  = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      drop  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      drop  <= drop_next;
    end
  end

  `SRAC_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_WIDTH'(MAX_LEN), "key count above capacity")
  `SRAC_ASSERT_NOW(a_drain_nonempty, state == ST_DRAIN, count != '0, "draining an empty row")
  `SRAC_ASSERT_NEXT(a_run_ends, result_take && end_of_run,
                    state == ST_LOAD && count == '0 && !drop, "run end did not clear")
  `SRAC_ASSERT_NEXT(a_run_continues, result_take && !end_of_run,
                    state == ST_DRAIN, "drain left before the last result")

endmodule

// ===== tb/stable_rank_argsort_core_tb.sv =====
`timescale 1ns / 100ps

module stable_rank_argsort_core_tb;
  import srac_pkg::*;

  localparam int MAX_LEN      = DEF_MAX_LEN;
  localparam int MAX_WAIT     = 14;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 2 * DEF_MAX_LEN + 16;
  localparam int RANDOM_ITEMS = 115;

  localparam logic signed [IN_KEY_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [IN_KEY_WIDTH-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef logic signed [IN_KEY_WIDTH-1:0] key_t;

  typedef enum int {
    KEY_ANY,
    KEY_TIES,
    KEY_EDGES
  } key_style_e;

  typedef struct packed {
    logic [IDX_WIDTH-1:0] index;
    logic                 last;
    logic                 dropped;
  } order_entry_t;

  logic                    clk;
  logic                    rst;
  logic                    item_valid;
  logic                    item_stall;
  logic [IN_KEY_WIDTH-1:0] key_value;
  logic                    is_final;
  logic                    result_valid;
  logic                    result_stall;
  logic [IDX_WIDTH-1:0]    sorted_index;
  logic                    end_of_run;
  logic                    overflowed;

  key_t         model_keys[$];
  logic         model_dropped;
  order_entry_t pending_order_q[$];

  bit tx_steady;
  bit rx_steady;
  int cycle_count;
  int error_count;
  int keys_sent;
  int vectors_done;
  int overflow_vectors;
  int results_checked;

  stable_rank_argsort_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .key_value    (key_value),
    .is_final     (is_final),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sorted_index (sorted_index),
    .end_of_run   (end_of_run),
    .overflowed   (overflowed)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_order_q.size());
      $display("** stable_rank_argsort_core: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Stable ascending order: a key's rank counts the earlier keys it is not below and the
  // later keys it is strictly above.
  task automatic predict_key(input key_t key, input logic fin);
    int           n;
    int           rank;
    int           slot[MAX_LEN];
    order_entry_t entry;
    if (model_keys.size() < MAX_LEN) begin
      model_keys.push_back(key);
    end else begin
      model_dropped = 1'b1;
    end
    if (!fin) return;
    n = model_keys.size();
    for (int i = 0; i < n; i++) begin
      rank = 0;
      for (int j = 0; j < n; j++) begin
        if (j < i && model_keys[i] >= model_keys[j]) rank++;
        if (j > i && model_keys[i] > model_keys[j]) rank++;
      end
      slot[rank] = i;
    end
    for (int r = 0; r < n; r++) begin
      entry.index   = slot[r][IDX_WIDTH-1:0];
      entry.last    = (r == n - 1);
      entry.dropped = model_dropped;
      pending_order_q.push_back(entry);
    end
    vectors_done++;
    if (model_dropped) overflow_vectors++;
    model_keys.delete();
    model_dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    order_entry_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pending_order_q.size() == 0) begin
        report_mismatch("unexpected result index", sorted_index, 0);
      end else begin
        want = pending_order_q.pop_front();
        results_checked++;
        if (sorted_index !== want.index) report_mismatch("sorted_index", sorted_index, want.index);
        if (end_of_run !== want.last) report_mismatch("end_of_run", end_of_run, want.last);
        if (overflowed !== want.dropped) report_mismatch("overflowed", overflowed, want.dropped);
      end
    end
  end

  initial begin
    int n;
    result_stall = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      n = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (result_valid !== 1'b1) @(posedge clk);
    end
  end

  task automatic send_key(input key_t key, input logic fin);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    key_value  <= key;
    is_final   <= fin;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    keys_sent++;
    predict_key(key, fin);
  endtask

  task automatic send_vector(input key_t keys[$]);
    foreach (keys[i]) send_key(keys[i], i == keys.size() - 1);
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    while (pending_order_q.size() != 0) @(posedge clk);
  endtask

  function automatic key_t pick_key(input key_style_e style);
    key_t edges[4];
    edges = '{KEY_MIN, KEY_MAX, 0, -1};
    case (style)
      KEY_TIES:  return $signed($urandom_range(0, 7)) - 4;
      KEY_EDGES: return edges[$urandom_range(0, 3)];
      default:   return $urandom;
    endcase
  endfunction

  function automatic key_style_e pick_style();
    case ($urandom_range(0, 3))
      0:       return KEY_TIES;
      1:       return KEY_EDGES;
      default: return KEY_ANY;
    endcase
  endfunction

  task automatic send_random_vector(input int len, input key_style_e style);
    key_t keys[$];
    for (int i = 0; i < len; i++) begin
      keys.push_back(($urandom_range(0, 4) == 0) ? pick_key(pick_style()) : pick_key(style));
    end
    send_vector(keys);
  endtask

  task automatic test_single_key_vectors();
    send_key(KEY_MIN, 1'b1);
    send_key(KEY_MAX, 1'b1);
    send_key(0, 1'b1);
    wait_for_results();
  endtask

  task automatic test_extremes_and_ties();
    key_t keys[$];
    keys = {key_t'(0), KEY_MAX, KEY_MIN, key_t'(-1), key_t'(1), KEY_MAX, KEY_MIN,
            key_t'(0), key_t'(32'sh7fff_fffe), key_t'(32'sh8000_0001), key_t'(-1), key_t'(0)};
    send_vector(keys);
    keys = {key_t'(32'sh1234_5678), key_t'(32'sh1234_5678), key_t'(32'sh1234_5678),
            key_t'(32'sh1234_5678), key_t'(32'sh1234_5678)};
    send_vector(keys);
    keys = {key_t'(5), key_t'(4), key_t'(3), key_t'(2), key_t'(1)};
    send_vector(keys);
    wait_for_results();
  endtask

  // A vector that fills every cell, then one whose last three keys, the final one among
  // them, are dropped.
  task automatic test_capacity_overflow();
    tx_steady = 1'b1;
    send_random_vector(MAX_LEN, KEY_TIES);
    wait_for_results();
    tx_steady = 1'b0;
    rx_steady = 1'b1;
    send_random_vector(MAX_LEN + 3, KEY_ANY);
    wait_for_results();
    rx_steady = 1'b0;
  endtask

  task automatic test_random_vectors();
    int start;
    int len;
    int count;
    start = keys_sent;
    count = 0;
    while (keys_sent - start < RANDOM_ITEMS) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      send_random_vector(len, pick_style());
      count++;
      if (count % 8 == 0) wait_for_results();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    item_valid       = 1'b0;
    key_value        = '0;
    is_final         = 1'b0;
    model_dropped    = 1'b0;
    tx_steady        = 1'b0;
    rx_steady        = 1'b0;
    cycle_count      = 0;
    error_count      = 0;
    keys_sent        = 0;
    vectors_done     = 0;
    overflow_vectors = 0;
    results_checked  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_single_key_vectors();
    test_extremes_and_ties();
    test_capacity_overflow();
    test_random_vectors();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sorted %0d vectors from %0d key transactions, %0d of them with dropped keys.",
             vectors_done, keys_sent, overflow_vectors);
    $display("Checked %0d result transactions; %0d mismatches.", results_checked, error_count);
    if (error_count == 0 && pending_order_q.size() == 0) begin
      $display("** stable_rank_argsort_core: PASSED **");
    end else begin
      $display("** stable_rank_argsort_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== stable_rank_argsort_core.f =====
+incdir+src
src/srac_pkg.sv
src/srac_cell.sv
src/stable_rank_argsort_core.sv
tb/stable_rank_argsort_core_tb.sv
